// ===== design/qpe_pkg.sv =====
// Shared types, constants and helper functions for the quintic path point evaluator.
// No dependencies; every other design file imports this package.
package qpe_pkg;

	localparam int FRAC_BITS_DEF  = 16;
	localparam int COEF_WIDTH_DEF = 32;

	localparam int S_W       = 17;
	localparam int S_FRAC    = 16;
	localparam int ACC_W     = 47;
	localparam int OUT_W     = 32;
	localparam int NUM_COEF  = 6;
	localparam int NUM_AXES  = 2;
	localparam int NUM_POLY  = 3;
	localparam int H_STAGES  = 5;

	localparam int AX_X  = 0;
	localparam int AX_Y  = 1;
	localparam int P_POS = 0;
	localparam int P_VEL = 1;
	localparam int P_ACC = 2;

	localparam int CFG_DATA_W  = 64;
	localparam int CFG_ADDR_W  = 6;
	localparam int CFG_IDX_LSB = 3;
	localparam int CFG_IDX_W   = 3;
	localparam int MIN_SQ_W    = 32;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED = 3'd6;
	localparam logic [MIN_SQ_W-1:0]  MIN_SQ_RESET  = 32'd43;

	localparam int V_W     = 64;
	localparam int E_W     = 5;
	localparam int R_W     = 32;
	localparam int MAGSH_W = V_W + (1 << E_W) - 1;
	localparam int DEN_W   = 96;
	localparam int Q_W     = 32;

	typedef struct packed {
		logic signed [OUT_W-1:0] pos_x;
		logic signed [OUT_W-1:0] pos_y;
		logic signed [OUT_W-1:0] vel_x;
		logic signed [OUT_W-1:0] vel_y;
		logic signed [OUT_W-1:0] acc_x;
		logic signed [OUT_W-1:0] acc_y;
	} kin_t;

	function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [ACC_W-1:0] v);
		logic [ACC_W-OUT_W:0] top;
		top = v[ACC_W-1:OUT_W-1];
		if ((&top) || !(|top)) begin
			sat_out = v[OUT_W-1:0];
		end else if (v[ACC_W-1]) begin
			sat_out = {1'b1, {(OUT_W-1){1'b0}}};
		end else begin
			sat_out = {1'b0, {(OUT_W-1){1'b1}}};
		end
	endfunction

endpackage

// ===== design/quintic_path_point_evaluator.sv =====
// Quintic path point evaluator takes one path parameter per clock unless stalled
// and returns position, first and second derivative and signed curvature for it.
// Every beat passes through five Horner stages, five stages of saturation,
// products and normalisation, 32 square root stages, three stages forming the
// divisor, 32 divider stages and the output register. The rate is one beat per
// cycle; the whole pipeline holds while a result is stalled.
// Depends on qpe_pkg, qpe_apb_regs, qpe_horner and qpe_curv.
module quintic_path_point_evaluator import qpe_pkg::*; #(
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [CFG_ADDR_W-1:0]   paddr,
	input  logic [CFG_DATA_W-1:0]   pwdata,
	output logic [CFG_DATA_W-1:0]   prdata,
	output logic                    pready,
	input  logic                    item_valid,
	output logic                    item_stall,
	input  logic [S_W-1:0]          s_param,
	output logic                    res_valid,
	input  logic                    res_stall,
	output logic signed [OUT_W-1:0] pos_x,
	output logic signed [OUT_W-1:0] pos_y,
	output logic signed [OUT_W-1:0] vel_x,
	output logic signed [OUT_W-1:0] vel_y,
	output logic signed [OUT_W-1:0] acc_x,
	output logic signed [OUT_W-1:0] acc_y,
	output logic signed [OUT_W-1:0] curvature,
	output logic                    curv_undefined
);

	logic signed [COEF_WIDTH-1:0] coef [NUM_AXES][NUM_COEF];
	logic [MIN_SQ_W-1:0]          min_sq;
	logic                         en;
	logic                         h_valid;
	logic signed [ACC_W-1:0]      h [NUM_POLY][NUM_AXES];
	kin_t                         kin;

	assign pready     = 1'b1;
	assign en         = !(res_valid && res_stall);
	assign item_stall = !en;

	qpe_apb_regs #(
		.COEF_WIDTH (COEF_WIDTH)
	) u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.coef    (coef),
		.min_sq  (min_sq)
	);

	qpe_horner #(
		.COEF_WIDTH (COEF_WIDTH)
	) u_horner (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_in  (item_valid),
		.s_in      (s_param),
		.coef      (coef),
		.valid_out (h_valid),
		.h_out     (h)
	);

	qpe_curv #(
		.FRAC_BITS (FRAC_BITS)
	) u_curv (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_in  (h_valid),
		.h_in      (h),
		.min_sq    (min_sq),
		.valid_out (res_valid),
		.kin_out   (kin),
		.curv_out  (curvature),
		.undef_out (curv_undefined)
	);

	assign pos_x = kin.pos_x;
	assign pos_y = kin.pos_y;
	assign vel_x = kin.vel_x;
	assign vel_y = kin.vel_y;
	assign acc_x = kin.acc_x;
	assign acc_y = kin.acc_y;

endmodule

// ===== design/qpe_apb_regs.sv =====
// Configuration register file: six coefficient pairs and the squared speed floor.
// Depends on qpe_pkg.
module qpe_apb_regs import qpe_pkg::*; #(
	parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [CFG_ADDR_W-1:0]        paddr,
	input  logic [CFG_DATA_W-1:0]        pwdata,
	output logic [CFG_DATA_W-1:0]        prdata,
	output logic signed [COEF_WIDTH-1:0] coef [NUM_AXES][NUM_COEF],
	output logic [MIN_SQ_W-1:0]          min_sq
);

	logic [CFG_DATA_W-1:0] coef_q [NUM_COEF];
	logic [MIN_SQ_W-1:0]   min_sq_q;
	logic [CFG_IDX_W-1:0]  idx;

	assign idx = paddr[CFG_IDX_LSB +: CFG_IDX_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_COEF; k++) begin
				coef_q[k] <= '0;
			end
			min_sq_q <= MIN_SQ_RESET;
		end else if (psel && penable && pwrite) begin
			if (idx < CFG_IDX_W'(NUM_COEF)) begin
				coef_q[idx] <= pwdata;
			end else if (idx == REG_MIN_SPEED) begin
				min_sq_q <= pwdata[MIN_SQ_W-1:0];
			end
		end
	end

	always_comb begin
		prdata = '0;
		if (idx < CFG_IDX_W'(NUM_COEF)) begin
			prdata = coef_q[idx];
		end else if (idx == REG_MIN_SPEED) begin
			prdata = CFG_DATA_W'(min_sq_q);
		end
	end

	// Only the low COEF_WIDTH bits of each half carry the two's complement value.
	always_comb begin
		for (int k = 0; k < NUM_COEF; k++) begin
			coef[AX_X][k] = coef_q[k][32 +: COEF_WIDTH];
			coef[AX_Y][k] = coef_q[k][0 +: COEF_WIDTH];
		end
	end

	assign min_sq = min_sq_q;

endmodule

// ===== design/qpe_horner.sv =====
// Five-stage Horner pipeline for position, first and second derivative on both axes.
// Depends on qpe_pkg.
module qpe_horner import qpe_pkg::*; #(
	parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         valid_in,
	input  logic [S_W-1:0]               s_in,
	input  logic signed [COEF_WIDTH-1:0] coef [NUM_AXES][NUM_COEF],
	output logic                         valid_out,
	output logic signed [ACC_W-1:0]      h_out [NUM_POLY][NUM_AXES]
);

	localparam int P_W   = ACC_W + S_W + 1;
	localparam int QT_W  = P_W - S_FRAC;
	localparam int SUM_W = QT_W + 1;

	function automatic logic signed [ACC_W-1:0] term_of(
		input logic signed [COEF_WIDTH-1:0] c,
		input int m
	);
		term_of = ACC_W'(c) * ACC_W'(m);
	endfunction

	// One Horner step: round half up after the multiply, add the term, clamp to 47 bits.
	function automatic logic signed [ACC_W-1:0] hstep(
		input logic signed [ACC_W-1:0] h,
		input logic [S_W-1:0]          s,
		input logic signed [ACC_W-1:0] t
	);
		logic signed [P_W-1:0]   p;
		logic signed [QT_W-1:0]  q;
		logic signed [SUM_W-1:0] sm;
		logic [SUM_W-ACC_W:0]    top;
		p   = P_W'(h) * $signed({1'b0, s}) + (P_W'(1) <<< (S_FRAC - 1));
		q   = QT_W'(p >>> S_FRAC);
		sm  = SUM_W'(q) + SUM_W'(t);
		top = sm[SUM_W-1:ACC_W-1];
		if ((&top) || !(|top)) begin
			hstep = sm[ACC_W-1:0];
		end else if (sm[SUM_W-1]) begin
			hstep = {1'b1, {(ACC_W-1){1'b0}}};
		end else begin
			hstep = {1'b0, {(ACC_W-1){1'b1}}};
		end
	endfunction

	logic                    v_s   [H_STAGES];
	logic [S_W-1:0]          s_s   [H_STAGES];
	logic signed [ACC_W-1:0] h_s   [H_STAGES][NUM_POLY][NUM_AXES];
	logic [S_W-1:0]          cur_s [H_STAGES];
	logic signed [ACC_W-1:0] cur_h [H_STAGES][NUM_POLY][NUM_AXES];
	logic signed [ACC_W-1:0] nxt_h [H_STAGES][NUM_POLY][NUM_AXES];

	always_comb begin
		cur_s[0] = s_in;
		for (int a = 0; a < NUM_AXES; a++) begin
			cur_h[0][P_POS][a] = term_of(coef[a][5], 1);
			cur_h[0][P_VEL][a] = term_of(coef[a][5], 5);
			cur_h[0][P_ACC][a] = term_of(coef[a][5], 20);
		end
		for (int j = 1; j < H_STAGES; j++) begin
			cur_s[j] = s_s[j-1];
			for (int p = 0; p < NUM_POLY; p++) begin
				for (int a = 0; a < NUM_AXES; a++) begin
					cur_h[j][p][a] = h_s[j-1][p][a];
				end
			end
		end
	end

	// The derivative polynomials are shorter, so they hold their start value
	// through the first stages and join the steps later.
	always_comb begin
		for (int a = 0; a < NUM_AXES; a++) begin
			for (int j = 0; j < H_STAGES; j++) begin
				nxt_h[j][P_POS][a] = hstep(cur_h[j][P_POS][a], cur_s[j],
					term_of(coef[a][4-j], 1));
			end
			nxt_h[0][P_VEL][a] = cur_h[0][P_VEL][a];
			for (int j = 1; j < H_STAGES; j++) begin
				nxt_h[j][P_VEL][a] = hstep(cur_h[j][P_VEL][a], cur_s[j],
					term_of(coef[a][5-j], 5 - j));
			end
			nxt_h[0][P_ACC][a] = cur_h[0][P_ACC][a];
			nxt_h[1][P_ACC][a] = cur_h[1][P_ACC][a];
			for (int j = 2; j < H_STAGES; j++) begin
				nxt_h[j][P_ACC][a] = hstep(cur_h[j][P_ACC][a], cur_s[j],
					term_of(coef[a][6-j], (6 - j) * (5 - j)));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < H_STAGES; j++) begin
				s_s[j] <= cur_s[j];
				for (int p = 0; p < NUM_POLY; p++) begin
					for (int a = 0; a < NUM_AXES; a++) begin
						h_s[j][p][a] <= nxt_h[j][p][a];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < H_STAGES; j++) begin
				v_s[j] <= 1'b0;
			end
		end else if (en) begin
			v_s[0] <= valid_in;
			for (int j = 1; j < H_STAGES; j++) begin
				v_s[j] <= v_s[j-1];
			end
		end
	end

	assign valid_out = v_s[H_STAGES-1];

	always_comb begin
		for (int p = 0; p < NUM_POLY; p++) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				h_out[p][a] = h_s[H_STAGES-1][p][a];
			end
		end
	end

endmodule

// ===== design/qpe_isqrt.sv =====
// Pipelined integer square root of a normalised 64-bit word, one result bit per stage.
// Depends on qpe_pkg; carries a sideband word alongside each beat.
module qpe_isqrt import qpe_pkg::*; #(
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              valid_in,
	input  logic [V_W-1:0]    w_in,
	input  logic [SIDE_W-1:0] side_in,
	output logic              valid_out,
	output logic [R_W-1:0]    r_out,
	output logic [SIDE_W-1:0] side_out
);

	logic              v_s      [R_W];
	logic [V_W-1:0]    w_s      [R_W];
	logic [V_W-1:0]    r_s      [R_W];
	logic [SIDE_W-1:0] side_s   [R_W];
	logic [V_W-1:0]    cur_w    [R_W];
	logic [V_W-1:0]    cur_r    [R_W];
	logic [SIDE_W-1:0] cur_side [R_W];
	logic [V_W-1:0]    trial    [R_W];
	logic [V_W-1:0]    nxt_w    [R_W];
	logic [V_W-1:0]    nxt_r    [R_W];

	always_comb begin
		cur_w[0]    = w_in;
		cur_r[0]    = '0;
		cur_side[0] = side_in;
		for (int i = 1; i < R_W; i++) begin
			cur_w[i]    = w_s[i-1];
			cur_r[i]    = r_s[i-1];
			cur_side[i] = side_s[i-1];
		end
		for (int i = 0; i < R_W; i++) begin
			trial[i] = cur_r[i] + (V_W'(1) << (V_W - 2 - 2 * i));
			if (cur_w[i] >= trial[i]) begin
				nxt_w[i] = cur_w[i] - trial[i];
				nxt_r[i] = (cur_r[i] >> 1) + (V_W'(1) << (V_W - 2 - 2 * i));
			end else begin
				nxt_w[i] = cur_w[i];
				nxt_r[i] = cur_r[i] >> 1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < R_W; i++) begin
				w_s[i]    <= nxt_w[i];
				r_s[i]    <= nxt_r[i];
				side_s[i] <= cur_side[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < R_W; i++) begin
				v_s[i] <= 1'b0;
			end
		end else if (en) begin
			v_s[0] <= valid_in;
			for (int i = 1; i < R_W; i++) begin
				v_s[i] <= v_s[i-1];
			end
		end
	end

	assign valid_out = v_s[R_W-1];
	assign r_out     = r_s[R_W-1][R_W-1:0];
	assign side_out  = side_s[R_W-1];

endmodule

// ===== design/qpe_div.sv =====
// Pipelined restoring divider producing a 32-bit quotient, one bit per stage.
// Depends on qpe_pkg; carries a sideband word alongside each beat.
module qpe_div import qpe_pkg::*; #(
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              valid_in,
	input  logic [DEN_W-1:0]  den_in,
	input  logic [DEN_W-1:0]  rem_in,
	input  logic [Q_W-1:0]    low_in,
	input  logic [SIDE_W-1:0] side_in,
	output logic              valid_out,
	output logic [Q_W-1:0]    q_out,
	output logic [SIDE_W-1:0] side_out
);

	logic              v_s      [Q_W];
	logic [DEN_W-1:0]  den_s    [Q_W];
	logic [DEN_W-1:0]  rem_s    [Q_W];
	logic [Q_W-1:0]    low_s    [Q_W];
	logic [Q_W-1:0]    q_s      [Q_W];
	logic [SIDE_W-1:0] side_s   [Q_W];
	logic [DEN_W-1:0]  cur_den  [Q_W];
	logic [DEN_W-1:0]  cur_rem  [Q_W];
	logic [Q_W-1:0]    cur_low  [Q_W];
	logic [Q_W-1:0]    cur_q    [Q_W];
	logic [SIDE_W-1:0] cur_side [Q_W];
	logic [DEN_W:0]    rem2     [Q_W];
	logic              ge       [Q_W];
	logic [DEN_W-1:0]  nxt_rem  [Q_W];

	always_comb begin
		cur_den[0]  = den_in;
		cur_rem[0]  = rem_in;
		cur_low[0]  = low_in;
		cur_q[0]    = '0;
		cur_side[0] = side_in;
		for (int i = 1; i < Q_W; i++) begin
			cur_den[i]  = den_s[i-1];
			cur_rem[i]  = rem_s[i-1];
			cur_low[i]  = low_s[i-1];
			cur_q[i]    = q_s[i-1];
			cur_side[i] = side_s[i-1];
		end
		for (int i = 0; i < Q_W; i++) begin
			rem2[i] = {cur_rem[i], cur_low[i][Q_W-1]};
			ge[i]   = rem2[i] >= {1'b0, cur_den[i]};
			if (ge[i]) begin
				nxt_rem[i] = DEN_W'(rem2[i] - {1'b0, cur_den[i]});
			end else begin
				nxt_rem[i] = rem2[i][DEN_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < Q_W; i++) begin
				den_s[i]  <= cur_den[i];
				rem_s[i]  <= nxt_rem[i];
				low_s[i]  <= cur_low[i] << 1;
				q_s[i]    <= {cur_q[i][Q_W-2:0], ge[i]};
				side_s[i] <= cur_side[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < Q_W; i++) begin
				v_s[i] <= 1'b0;
			end
		end else if (en) begin
			v_s[0] <= valid_in;
			for (int i = 1; i < Q_W; i++) begin
				v_s[i] <= v_s[i-1];
			end
		end
	end

	assign valid_out = v_s[Q_W-1];
	assign q_out     = q_s[Q_W-1];
	assign side_out  = side_s[Q_W-1];

endmodule

// ===== design/qpe_curv.sv =====
// Saturation of the Horner results and the signed curvature pipeline.
// Depends on qpe_pkg, qpe_isqrt and qpe_div.
module qpe_curv import qpe_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    valid_in,
	input  logic signed [ACC_W-1:0] h_in [NUM_POLY][NUM_AXES],
	input  logic [MIN_SQ_W-1:0]     min_sq,
	output logic                    valid_out,
	output kin_t                    kin_out,
	output logic signed [OUT_W-1:0] curv_out,
	output logic                    undef_out
);

	localparam int N2_W  = MAGSH_W + 2 * FRAC_BITS;
	localparam int CMP_W = (N2_W > DEN_W + Q_W) ? N2_W : DEN_W + Q_W;

	typedef struct packed {
		kin_t           kin;
		logic [V_W-1:0] vsq;
		logic [V_W-1:0] mag;
		logic [E_W-1:0] e;
		logic           neg;
		logic           undef;
	} sq_side_t;

	typedef struct packed {
		kin_t kin;
		logic neg;
		logic undef;
		logic ovf;
	} dv_side_t;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;

	kin_t                kin_s1, kin_s2, kin_s3, kin_s4, kin_s6, kin_s7;
	logic signed [63:0]  xx_s2, yy_s2, n1_s2, n2_s2;
	logic [V_W-1:0]      vsq_s3, vsq_s4;
	logic signed [64:0]  num_s3;
	logic                undef_s3, undef_s4, undef_s6, undef_s7;
	logic [V_W-1:0]      mag_s4;
	logic                neg_s4, neg_s6, neg_s7;
	logic [E_W-1:0]      e_s4;
	sq_side_t            side_s5;
	logic [V_W-1:0]      w_s5;
	logic [63:0]         a_s6, b_s6;
	logic [MAGSH_W-1:0]  ash_s6;
	logic [DEN_W-1:0]    den_s7;
	logic [N2_W-1:0]     n2_s7;
	logic [DEN_W-1:0]    den_s8, rem_s8;
	logic [Q_W-1:0]      low_s8;
	dv_side_t            dside_s8;
	kin_t                kin_s9;
	logic signed [OUT_W-1:0] curv_s9;
	logic                undef_s9;

	kin_t                kin_c;
	logic [V_W-1:0]      vsq_c;
	logic                undef_c;
	logic [64:0]         abs_c;
	logic [6:0]          lz_c;
	logic                ovf_c;
	logic                sq_valid;
	logic [R_W-1:0]      sq_r;
	sq_side_t            sq_side;
	logic                dv_valid;
	logic [Q_W-1:0]      dv_q;
	dv_side_t            dv_side;
	logic                big_c;
	logic signed [OUT_W-1:0] curv_c;

	always_comb begin
		kin_c.pos_x = sat_out(h_in[P_POS][AX_X]);
		kin_c.pos_y = sat_out(h_in[P_POS][AX_Y]);
		kin_c.vel_x = sat_out(h_in[P_VEL][AX_X]);
		kin_c.vel_y = sat_out(h_in[P_VEL][AX_Y]);
		kin_c.acc_x = sat_out(h_in[P_ACC][AX_X]);
		kin_c.acc_y = sat_out(h_in[P_ACC][AX_Y]);
	end

	always_comb begin
		vsq_c   = $unsigned(xx_s2) + $unsigned(yy_s2);
		undef_c = (vsq_c == '0) || (vsq_c < V_W'(min_sq));
	end

	// Magnitude of the numerator and the normalising exponent: e is half the
	// count of leading zeros, so that the shifted square lands in [2^62, 2^64).
	always_comb begin
		abs_c = num_s3[64] ? 65'(-num_s3) : num_s3;
		lz_c  = 7'd64;
		for (int i = 0; i < V_W; i++) begin
			if (vsq_s3[i]) begin
				lz_c = 7'(V_W - 1 - i);
			end
		end
	end

	assign ovf_c = CMP_W'(n2_s7) >= CMP_W'({den_s7, {Q_W{1'b0}}});

	always_ff @(posedge clk) begin
		if (en) begin
			kin_s1 <= kin_c;

			kin_s2 <= kin_s1;
			xx_s2  <= kin_s1.vel_x * kin_s1.vel_x;
			yy_s2  <= kin_s1.vel_y * kin_s1.vel_y;
			n1_s2  <= kin_s1.vel_x * kin_s1.acc_y;
			n2_s2  <= kin_s1.vel_y * kin_s1.acc_x;

			kin_s3   <= kin_s2;
			vsq_s3   <= vsq_c;
			num_s3   <= $signed({n1_s2[63], n1_s2}) - $signed({n2_s2[63], n2_s2});
			undef_s3 <= undef_c;

			kin_s4   <= kin_s3;
			vsq_s4   <= vsq_s3;
			mag_s4   <= abs_c[V_W-1:0];
			neg_s4   <= num_s3[64];
			undef_s4 <= undef_s3;
			e_s4     <= lz_c[E_W:1];

			side_s5.kin   <= kin_s4;
			side_s5.vsq   <= vsq_s4;
			side_s5.mag   <= mag_s4;
			side_s5.e     <= e_s4;
			side_s5.neg   <= neg_s4;
			side_s5.undef <= undef_s4;
			w_s5          <= vsq_s4 << {e_s4, 1'b0};

			// The 64 x 32 denominator product is split into two 32 x 32 halves.
			kin_s6   <= sq_side.kin;
			neg_s6   <= sq_side.neg;
			undef_s6 <= sq_side.undef;
			a_s6     <= 64'(sq_side.vsq[31:0]) * 64'(sq_r);
			b_s6     <= 64'(sq_side.vsq[63:32]) * 64'(sq_r);
			ash_s6   <= MAGSH_W'(sq_side.mag) << sq_side.e;

			kin_s7   <= kin_s6;
			neg_s7   <= neg_s6;
			undef_s7 <= undef_s6;
			den_s7   <= {b_s6, 32'd0} + DEN_W'(a_s6);
			n2_s7    <= N2_W'(ash_s6) << (2 * FRAC_BITS);

			// With no overflow the top part of the dividend is already below the divisor.
			den_s8         <= den_s7;
			rem_s8         <= DEN_W'(n2_s7 >> Q_W);
			low_s8         <= n2_s7[Q_W-1:0];
			dside_s8.kin   <= kin_s7;
			dside_s8.neg   <= neg_s7;
			dside_s8.undef <= undef_s7;
			dside_s8.ovf   <= ovf_c;

			kin_s9   <= dv_side.kin;
			curv_s9  <= curv_c;
			undef_s9 <= dv_side.undef;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s1 <= valid_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= sq_valid;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= dv_valid;
		end
	end

	qpe_isqrt #(
		.SIDE_W ($bits(sq_side_t))
	) u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_in  (v_s5),
		.w_in      (w_s5),
		.side_in   (side_s5),
		.valid_out (sq_valid),
		.r_out     (sq_r),
		.side_out  (sq_side)
	);

	qpe_div #(
		.SIDE_W ($bits(dv_side_t))
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_in  (v_s8),
		.den_in    (den_s8),
		.rem_in    (rem_s8),
		.low_in    (low_s8),
		.side_in   (dside_s8),
		.valid_out (dv_valid),
		.q_out     (dv_q),
		.side_out  (dv_side)
	);

	always_comb begin
		big_c = dv_side.ovf || dv_q[Q_W-1];
		if (dv_side.undef) begin
			curv_c = '0;
		end else if (big_c) begin
			curv_c = dv_side.neg ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
		end else if (dv_side.neg) begin
			curv_c = -$signed(OUT_W'(dv_q));
		end else begin
			curv_c = $signed(OUT_W'(dv_q));
		end
	end

	assign valid_out = v_s9;
	assign kin_out   = kin_s9;
	assign curv_out  = curv_s9;
	assign undef_out = undef_s9;

endmodule

// ===== design/qpe_checker.sv =====
// Port-level checker for the quintic path point evaluator, bound to the top level.
// Depends on qpe_pkg.
module qpe_checker import qpe_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    item_stall,
	input logic                    res_valid,
	input logic                    res_stall,
	input logic signed [OUT_W-1:0] vel_x,
	input logic signed [OUT_W-1:0] vel_y,
	input logic signed [OUT_W-1:0] acc_x,
	input logic signed [OUT_W-1:0] acc_y,
	input logic signed [OUT_W-1:0] curvature,
	input logic                    curv_undefined
);

	// A stalled result beat keeps its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(curvature) && $stable(vel_x))
		else $error("stalled result beat changed");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> res_valid && res_stall)
		else $error("input stalled without a stalled result");

	a_undef_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && curv_undefined |-> curvature == '0)
		else $error("curvature not zero while undefined");

	// The sign of the curvature follows the cross product of velocity and acceleration.
	a_sign: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && curvature < 0 |->
		(64'(vel_x) * 64'(acc_y)) < (64'(vel_y) * 64'(acc_x)))
		else $error("negative curvature with a non-negative cross product");

endmodule

bind quintic_path_point_evaluator qpe_checker u_qpe_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.item_stall     (item_stall),
	.res_valid      (res_valid),
	.res_stall      (res_stall),
	.vel_x          (vel_x),
	.vel_y          (vel_y),
	.acc_x          (acc_x),
	.acc_y          (acc_y),
	.curvature      (curvature),
	.curv_undefined (curv_undefined)
);

// ===== bench/tb_top.sv =====
// Self-checking bench for the quintic path point evaluator: APB set-up of the
// coefficient pairs and speed floor, directed and random beats on both channels,
// and a local fixed-point predictor of the six kinematic outputs and the curvature.
// Depends on qpe_pkg and the design files.
`timescale 1ns / 1ps

module tb_top;
	import qpe_pkg::*;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] acc_x;
		logic signed [31:0] acc_y;
		logic signed [31:0] curv;
		logic               undef;
	} point_t;

	localparam int REG_COEF0 = 0;
	localparam int REG_FLOOR = 6;
	localparam int LATENCY   = 78;
	localparam int WATCH_LIM = 6000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [CFG_DATA_W-1:0] pwdata = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic pready;
	logic item_valid = 1'b0;
	logic item_stall;
	logic [S_W-1:0] s_param = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	logic signed [31:0] pos_x, pos_y, vel_x, vel_y, acc_x, acc_y, curvature;
	logic curv_undefined;

	logic [63:0] coef_pair [6];
	logic [31:0] speed_floor;
	point_t expected_points [$];
	int errors = 0;
	int hold_off = 0;
	int stall_wait = 0;
	bit calm_rx = 0;
	int idle_cycles = 0;

	quintic_path_point_evaluator dut (.*);

	always #2 clk = ~clk;

	function automatic longint horner_step(longint h, longint s, longint t);
		longint q;
		q = ((h * s + 64'sd32768) >>> 16) + t;
		if (q > (64'sd1 <<< 46) - 1) q = (64'sd1 <<< 46) - 1;
		if (q < -(64'sd1 <<< 46)) q = -(64'sd1 <<< 46);
		return q;
	endfunction

	function automatic longint sat32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic logic [63:0] int_sqrt(logic [63:0] w);
		logic [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > w) b = b >> 2;
		while (b != 0) begin
			if (w >= res + b) begin
				w = w - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic point_t eval_point(logic [16:0] s_in);
		point_t p;
		longint c [6];
		longint h, s, vx, vy, ax, ay, n;
		longint kin [6];
		logic [63:0] v2, mag, w;
		logic [191:0] num, den, q;
		int e;
		s = s_in;
		for (int axis = 0; axis < 2; axis++) begin
			for (int k = 0; k < 6; k++)
				c[k] = (axis == 0) ? longint'($signed(coef_pair[k][63:32]))
					: longint'($signed(coef_pair[k][31:0]));
			h = c[5];
			for (int k = 4; k >= 0; k--) h = horner_step(h, s, c[k]);
			kin[axis] = sat32(h);
			h = 5 * c[5];
			h = horner_step(h, s, 4 * c[4]);
			h = horner_step(h, s, 3 * c[3]);
			h = horner_step(h, s, 2 * c[2]);
			h = horner_step(h, s, c[1]);
			kin[2 + axis] = sat32(h);
			h = 20 * c[5];
			h = horner_step(h, s, 12 * c[4]);
			h = horner_step(h, s, 6 * c[3]);
			h = horner_step(h, s, 2 * c[2]);
			kin[4 + axis] = sat32(h);
		end
		vx = kin[2]; vy = kin[3]; ax = kin[4]; ay = kin[5];
		p.pos_x = 32'(kin[0]); p.pos_y = 32'(kin[1]);
		p.vel_x = 32'(vx); p.vel_y = 32'(vy); p.acc_x = 32'(ax); p.acc_y = 32'(ay);
		v2 = vx * vx + vy * vy;
		p.undef = (v2 == 0) || (v2 < {32'd0, speed_floor});
		p.curv = '0;
		if (!p.undef) begin
			n = vx * ay - vy * ax;
			mag = (n < 0) ? -n : n;
			w = v2;
			e = 0;
			while (w[63:62] == 2'b00) begin
				w = w << 2;
				e++;
			end
			den = {128'd0, v2} * {128'd0, int_sqrt(w)};
			num = {128'd0, mag} << (32 + e);
			q = num / den;
			if (q > (192'd1 << 33)) q = 192'd1 << 33;
			if (n < 0) p.curv = (q > 192'd2147483648) ? 32'h80000000 : -q[31:0];
			else p.curv = (q > 192'd2147483647) ? 32'h7fffffff : q[31:0];
		end
		return p;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h expected %h", what, got, want);
		errors++;
	endtask

	task automatic reg_write(int idx, logic [63:0] val);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= CFG_ADDR_W'(idx * 8); pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (idx < REG_FLOOR) coef_pair[idx] = val;
		else speed_floor = val[31:0];
	endtask

	// Waits for the pipeline to empty before any register is touched.
	task automatic drain();
		item_valid <= 1'b0;
		wait (expected_points.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic send_point(logic [16:0] s, int gap);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		s_param <= s;
		do @(posedge clk); while (item_stall);
		expected_points.push_back(eval_point(s));
	endtask

	function automatic logic [31:0] rand_coef();
		return $signed($urandom) >>> $urandom_range(0, 31);
	endfunction

	function automatic logic [16:0] rand_s();
		if ($urandom_range(0, 9) == 0) return 17'($urandom);
		return 17'($urandom_range(0, 65536));
	endfunction

	task automatic random_coefs();
		for (int k = 0; k < 6; k++) reg_write(REG_COEF0 + k, {rand_coef(), rand_coef()});
		case ($urandom_range(0, 3))
			0: reg_write(REG_FLOOR, 64'd0);
			1: reg_write(REG_FLOOR, 64'hffffffff);
			default: reg_write(REG_FLOOR, 64'($urandom >> $urandom_range(0, 31)));
		endcase
	endtask

	task automatic test_directed();
		logic [16:0] pts [5] = '{17'd0, 17'd1, 17'd32768, 17'd65536, 17'h1ffff};
		// All coefficients zero after reset: zero speed must flag.
		foreach (pts[i]) send_point(pts[i], 0);
		drain();
		reg_write(REG_FLOOR, 64'd0);
		reg_write(REG_COEF0 + 1, {32'h00010000, 32'h00000000});
		reg_write(REG_COEF0 + 2, {32'h00000000, 32'h00020000});
		foreach (pts[i]) send_point(pts[i], 1);
		send_point(17'd0, 0);
		drain();
		// Opposite turning sense and extreme coefficients to force clamping.
		reg_write(REG_COEF0 + 2, {32'h00000000, 32'hfffe0000});
		foreach (pts[i]) send_point(pts[i], 0);
		drain();
		for (int k = 0; k < 6; k++) reg_write(REG_COEF0 + k, {32'h7fffffff, 32'h80000000});
		reg_write(REG_FLOOR, 64'hffffffff);
		foreach (pts[i]) send_point(pts[i], 0);
		drain();
		for (int k = 0; k < 6; k++) reg_write(REG_COEF0 + k, {32'h80000000, 32'h7fffffff});
		reg_write(REG_FLOOR, 64'd0);
		foreach (pts[i]) send_point(pts[i], 0);
		drain();
	endtask

	task automatic test_random(int phases, int per_phase);
		for (int ph = 0; ph < phases; ph++) begin
			random_coefs();
			calm_rx = (ph % 4 == 3);
			for (int i = 0; i < per_phase; i++)
				send_point(rand_s(), (ph % 4 == 2) ? 0 : $urandom_range(0, 12));
			drain();
		end
		calm_rx = 0;
	endtask

	task automatic test_backpressure();
		random_coefs();
		hold_off = 400;
		for (int i = 0; i < 200; i++) send_point(rand_s(), 0);
		drain();
	endtask

	always @(posedge clk) begin
		if (hold_off > 0) begin
			res_stall <= 1'b1;
			hold_off <= hold_off - 1;
		end else if (stall_wait > 0) begin
			res_stall <= 1'b1;
			stall_wait <= stall_wait - 1;
		end else begin
			res_stall <= 1'b0;
			if (res_valid && !res_stall && !calm_rx) stall_wait <= $urandom_range(0, 12);
		end
	end

	always @(posedge clk) begin
		point_t want;
		if (res_valid && !res_stall) begin
			if (expected_points.size() == 0) begin
				$display("unexpected result beat");
				errors++;
			end else begin
				want = expected_points.pop_front();
				if (pos_x !== want.pos_x) report_mismatch("pos_x", pos_x, want.pos_x);
				if (pos_y !== want.pos_y) report_mismatch("pos_y", pos_y, want.pos_y);
				if (vel_x !== want.vel_x) report_mismatch("vel_x", vel_x, want.vel_x);
				if (vel_y !== want.vel_y) report_mismatch("vel_y", vel_y, want.vel_y);
				if (acc_x !== want.acc_x) report_mismatch("acc_x", acc_x, want.acc_x);
				if (acc_y !== want.acc_y) report_mismatch("acc_y", acc_y, want.acc_y);
				if (curvature !== want.curv)
					report_mismatch("curvature", curvature, want.curv);
				if (curv_undefined !== want.undef)
					report_mismatch("curv_undefined", 32'(curv_undefined), 32'(want.undef));
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (res_valid && !res_stall) || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCH_LIM) begin
			$display("tb_top failed");
			$finish;
		end
	end

	initial begin
		for (int k = 0; k < 6; k++) coef_pair[k] = 0;
		speed_floor = 32'd43;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(12, 130);
		test_backpressure();
		drain();
		if (errors == 0 && expected_points.size() == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end
endmodule
